// ----- src/qaws_pkg.sv -----
package qaws_pkg;

    localparam int LINE_MAX_DEF = 4096;
    localparam int QUEUE_DEPTH  = 4;

    localparam int UNIT_W    = 16;
    localparam int START_W   = 12;
    localparam int LEN_W     = 13;
    localparam int OUT_DATA_W = 32;

    localparam logic [UNIT_W-1:0] U_SPACE = 16'h0020;
    localparam logic [UNIT_W-1:0] U_TAB   = 16'h0009;
    localparam logic [UNIT_W-1:0] U_CR    = 16'h000D;
    localparam logic [UNIT_W-1:0] U_LF    = 16'h000A;
    localparam logic [UNIT_W-1:0] U_FF    = 16'h000C;
    localparam logic [UNIT_W-1:0] U_NUL   = 16'h0000;
    localparam logic [UNIT_W-1:0] U_SQ    = 16'h0027;
    localparam logic [UNIT_W-1:0] U_DQ    = 16'h0022;
    localparam logic [UNIT_W-1:0] U_BSL   = 16'h005C;

    // one scan request from the window front end to the scanner
    typedef struct packed {
        logic final_op;   // line end: flush open token or give end marker
        logic sp;         // head is whitespace
        logic sq;         // head is a single quote
        logic dq;         // head is a double quote
        logic bsl;        // head is a backslash
        logic triple;     // head opens a triple double quote
        logic la_sq;      // next unit is a single quote
        logic la_dq;      // next unit is a double quote
    } t_op;

    function automatic logic f_is_space(input logic [UNIT_W-1:0] u);
        return (u == U_SPACE) || (u == U_TAB) || (u == U_CR) || (u == U_LF) ||
               (u == U_FF) || (u == U_NUL);
    endfunction

    function automatic t_op f_classify(input logic [UNIT_W-1:0] head,
                                       input logic [UNIT_W-1:0] la0,
                                       input logic [UNIT_W-1:0] la1,
                                       input logic [UNIT_W-1:0] la2,
                                       input logic [1:0]        nla);
        t_op op;
        op.final_op = 1'b0;
        op.sp       = f_is_space(head);
        op.sq       = (head == U_SQ);
        op.dq       = (head == U_DQ);
        op.bsl      = (head == U_BSL);
        op.la_sq    = (nla != 2'd0) && (la0 == U_SQ);
        op.la_dq    = (nla != 2'd0) && (la0 == U_DQ);
        op.triple   = (nla[1] == 1'b1) && (la0 == U_DQ) && (la1 == U_DQ) &&
                      !((nla == 2'd3) && (la2 == U_DQ));
        return op;
    endfunction

endpackage

// ----- src/qaws_front.sv -----
module qaws_front #(
    parameter int LINE_MAX = qaws_pkg::LINE_MAX_DEF,
    parameter int POS_W    = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [qaws_pkg::UNIT_W-1:0] i_unit,
    input  logic                        i_has,
    input  logic                        i_fin,
    output logic                        o_push,
    output qaws_pkg::t_op               o_op,
    output logic [POS_W-1:0]            o_pos,
    input  logic                        i_full
);
    import qaws_pkg::*;

    logic [UNIT_W-1:0] r_win [3];
    logic [UNIT_W-1:0] n_win [3];
    logic [1:0]        r_fill, n_fill;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_drain, n_drain;
    logic              acc;
    logic [POS_W:0]    pos_sum;
    logic [POS_W-1:0]  pos_inc;

    assign o_ready = !r_drain && !i_full;
    assign acc     = i_valid && o_ready;
    assign pos_sum = {1'b0, r_pos} + (POS_W+1)'(1);
    assign pos_inc = (pos_sum > (POS_W+1)'(LINE_MAX)) ? POS_W'(LINE_MAX) : pos_sum[POS_W-1:0];

    always_comb begin
        n_win   = r_win;
        n_fill  = r_fill;
        n_pos   = r_pos;
        n_drain = r_drain;
        o_push  = 1'b0;
        o_op    = '0;
        o_pos   = r_pos;
        if (r_drain) begin
            if (!i_full) begin
                o_push = 1'b1;
                if (r_fill != 2'd0) begin
                    o_op     = f_classify(r_win[0], r_win[1], r_win[2], '0, r_fill - 2'd1);
                    n_win[0] = r_win[1];
                    n_win[1] = r_win[2];
                    n_fill   = r_fill - 2'd1;
                end else begin
                    o_op.final_op = 1'b1;
                    n_pos         = '0;
                    n_drain       = 1'b0;
                end
            end
        end else if (acc) begin
            if (i_has) begin
                n_pos = pos_inc;
                o_pos = pos_inc;
                case (r_fill)
                    2'd0: begin
                        n_win[0] = i_unit;
                        n_fill   = 2'd1;
                    end
                    2'd1: begin
                        n_win[1] = i_unit;
                        n_fill   = 2'd2;
                    end
                    2'd2: begin
                        n_win[2] = i_unit;
                        n_fill   = 2'd3;
                    end
                    default: begin
                        o_push   = 1'b1;
                        o_op     = f_classify(r_win[0], r_win[1], r_win[2], i_unit, 2'd3);
                        n_win[0] = r_win[1];
                        n_win[1] = r_win[2];
                        n_win[2] = i_unit;
                    end
                endcase
            end
            if (i_fin) begin
                n_drain = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_pos   <= '0;
            r_drain <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

// ----- src/qaws_fifo.sv -----
module qaws_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = qaws_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/qaws_back.sv -----
module qaws_back #(
    parameter int LINE_MAX = qaws_pkg::LINE_MAX_DEF,
    parameter int POS_W    = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  qaws_pkg::t_op                i_op,
    input  logic [POS_W-1:0]             i_pos,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [qaws_pkg::START_W-1:0] o_start,
    output logic [qaws_pkg::LEN_W-1:0]   o_len,
    output logic                         o_present,
    output logic                         o_last
);
    import qaws_pkg::*;

    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_SQUOTE  = 2'd2;
    localparam logic [1:0] MODE_DQUOTE  = 2'd3;
    localparam int         SW           = POS_W + 2;

    function automatic logic [POS_W-1:0] f_sat(input logic [SW-1:0] v);
        return (v > SW'(LINE_MAX)) ? POS_W'(LINE_MAX) : v[POS_W-1:0];
    endfunction

    logic [1:0]       r_mode, n_mode;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_len, n_len;
    logic             r_skip, n_skip;
    logic             r_esc, n_esc;
    logic [1:0]       r_absorb, n_absorb;

    logic             r_ov;
    logic [START_W-1:0] r_ostart;
    logic [LEN_W-1:0]   r_olen;
    logic             r_opres, r_olast;

    logic             go;
    logic             do_top, top_fresh;
    logic [POS_W-1:0] len_inc, start_inc, end_start, top_inc;
    logic             emit_ok;
    logic             res_v, res_pres, res_last;
    logic [POS_W-1:0] res_start, res_len;

    assign go      = i_valid && (!r_ov || i_ready);
    assign o_pop   = go;
    assign emit_ok = (r_start < i_pos);
    assign len_inc   = f_sat(SW'(r_len) + SW'(1));
    assign start_inc = f_sat(SW'(r_start) + SW'(1));
    assign end_start = f_sat(SW'(r_start) + SW'(r_len) + SW'(r_skip) + SW'(1));
    assign top_fresh = (r_mode == MODE_BETWEEN);
    assign top_inc   = top_fresh ? POS_W'(1) : len_inc;

    always_comb begin
        n_mode    = r_mode;
        n_start   = r_start;
        n_len     = r_len;
        n_skip    = r_skip;
        n_esc     = r_esc;
        n_absorb  = r_absorb;
        do_top    = 1'b0;
        res_v     = 1'b0;
        res_start = r_start;
        res_len   = r_len;
        res_pres  = 1'b1;
        res_last  = 1'b0;
        if (i_op.final_op) begin
            res_v    = 1'b1;
            res_last = 1'b1;
            if (!((r_mode != MODE_BETWEEN) && emit_ok)) begin
                res_start = '0;
                res_len   = '0;
                res_pres  = 1'b0;
            end
            n_mode   = MODE_BETWEEN;
            n_start  = '0;
            n_len    = '0;
            n_skip   = 1'b0;
            n_esc    = 1'b0;
            n_absorb = '0;
        end else if (r_absorb != 2'd0) begin
            n_absorb = r_absorb - 2'd1;
            n_len    = len_inc;
        end else begin
            case (r_mode)
                MODE_BETWEEN: begin
                    if (i_op.sp) begin
                        n_start = start_inc;
                    end else begin
                        n_mode    = MODE_WORD;
                        do_top    = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (i_op.sp) begin
                            res_v   = emit_ok;
                            n_start = end_start;
                            n_len   = '0;
                            n_mode  = MODE_BETWEEN;
                        end else begin
                            n_len = len_inc;
                        end
                    end else begin
                        do_top = 1'b1;
                    end
                end
                default: begin
                    n_len = len_inc;
                    if ((r_mode == MODE_SQUOTE) ? i_op.sq : i_op.dq) begin
                        n_mode = MODE_WORD;
                    end else if (i_op.bsl &&
                                 ((r_mode == MODE_SQUOTE) ? i_op.la_sq : i_op.la_dq)) begin
                        n_absorb = 2'd1;
                    end
                end
            endcase
            if (do_top) begin
                if (i_op.sq) begin
                    n_skip = 1'b0;
                    n_len  = POS_W'(1);
                    n_mode = MODE_SQUOTE;
                end else if (i_op.dq) begin
                    if (i_op.triple) begin
                        n_len    = POS_W'(3);
                        n_skip   = 1'b1;
                        n_absorb = 2'd2;
                        n_mode   = MODE_WORD;
                    end else begin
                        n_skip = 1'b0;
                        n_len  = POS_W'(1);
                        n_mode = MODE_DQUOTE;
                    end
                end else if (i_op.bsl && (i_op.la_sq || i_op.la_dq)) begin
                    n_len    = top_inc;
                    n_absorb = 2'd1;
                    n_esc    = 1'b1;
                end else if (i_op.sp) begin
                    // only reachable from inside a word
                    res_v   = emit_ok;
                    n_start = end_start;
                    n_len   = '0;
                    n_mode  = MODE_BETWEEN;
                    n_esc   = 1'b0;
                end else begin
                    n_len = top_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BETWEEN;
            r_start  <= '0;
            r_len    <= '0;
            r_skip   <= 1'b0;
            r_esc    <= 1'b0;
            r_absorb <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (go) begin
                r_mode   <= n_mode;
                r_start  <= n_start;
                r_len    <= n_len;
                r_skip   <= n_skip;
                r_esc    <= n_esc;
                r_absorb <= n_absorb;
            end
            if (!r_ov || i_ready) begin
                r_ov <= go && res_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_v) begin
            r_ostart <= START_W'(res_start);
            r_olen   <= LEN_W'(res_len);
            r_opres  <= res_pres;
            r_olast  <= res_last;
        end
    end

    assign o_valid   = r_ov;
    assign o_start   = r_ostart;
    assign o_len     = r_olen;
    assign o_present = r_opres;
    assign o_last    = r_olast;

endmodule

// ----- src/quote_aware_word_splitter_top.sv -----
// Quote-aware word splitter: takes a line one UTF-16 code unit per request and
// returns one record (start, length) per whitespace-separated token, quoted
// spans kept whole. A unit is taken every cycle while the line runs and the queue
// has room; each unit is held in a three-unit lookahead window before the scanner
// judges it. After the item that carries tlast, the window front end sends each
// unit still in the window and then the line-end flush, and it takes no new
// unit until the flush has gone. A four-entry queue separates the window front
// end from the scanner, and a result register separates the scanner from the
// output, so either side may stall on its own. Every line ends with exactly one
// result that has tlast set; it carries the last token, or tuser 0 and zero
// data when the line end closes no token.
module quote_aware_word_splitter_top #(
    parameter int LINE_MAX = qaws_pkg::LINE_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [qaws_pkg::UNIT_W-1:0]     i_s_axis_tdata,   // [15:0] code_unit
    input  logic                            i_s_axis_tuser,   // [0] has_unit
    input  logic                            i_s_axis_tlast,   // line_end
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [qaws_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,   // [11:0] token_start,
                                                              // [24:12] token_length
    output logic                            o_m_axis_tuser,   // [0] token_present
    output logic                            o_m_axis_tlast    // last_of_line
);
    import qaws_pkg::*;

    localparam int POS_W = $clog2(LINE_MAX + 1);
    localparam int OPW   = $bits(t_op);
    localparam int QW    = OPW + POS_W;

    logic             push, full, q_valid, pop;
    t_op              f_op;
    logic [POS_W-1:0] f_pos;
    logic [QW-1:0]    q_data;
    logic [START_W-1:0] b_start;
    logic [LEN_W-1:0]   b_len;

    qaws_front #(
        .LINE_MAX (LINE_MAX),
        .POS_W    (POS_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_unit  (i_s_axis_tdata),
        .i_has   (i_s_axis_tuser),
        .i_fin   (i_s_axis_tlast),
        .o_push  (push),
        .o_op    (f_op),
        .o_pos   (f_pos),
        .i_full  (full)
    );

    qaws_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_pos, f_op}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    qaws_back #(
        .LINE_MAX (LINE_MAX),
        .POS_W    (POS_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_pop     (pop),
        .i_op      (t_op'(q_data[OPW-1:0])),
        .i_pos     (q_data[QW-1:OPW]),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_start   (b_start),
        .o_len     (b_len),
        .o_present (o_m_axis_tuser),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - START_W - LEN_W)'(0), b_len, b_start};

endmodule

// ----- src/qaws_checker.sv -----
module qaws_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [qaws_pkg::UNIT_W-1:0]     i_s_axis_tdata,
    input logic                            i_s_axis_tuser,
    input logic                            i_s_axis_tlast,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [qaws_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=>
            i_s_axis_tvalid && $stable(i_s_axis_tdata) &&
            $stable(i_s_axis_tuser) && $stable(i_s_axis_tlast))
        else $error("waiting request changed");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("end marker without line end");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("end marker carries data");

endmodule

bind quote_aware_word_splitter_top qaws_checker u_qaws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
